>>> rtl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and constants for the multichannel bit-serial driver.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int BYTE_W    = 8;
    localparam int CH_W      = 5;
    localparam int SAMPLE_W  = 32;
    localparam int PIN_W     = 32;
    localparam int HDR_W     = 64;
    localparam int BIT_W     = 3;

    localparam int CLK_BIT   = 0;
    localparam int LATCH_BIT = 1;
    localparam int LANE_LSB  = 2;

    localparam logic REQ_BYTE   = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam logic KIND_PINS  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef struct packed {
        logic                valid;
        logic                reject;
        logic                zero_samples;
        logic                no_payload;
        logic [CH_W-1:0]     channels;
        logic [SAMPLE_W-1:0] samples;
    } hdr_res_t;

    typedef struct packed {
        logic             wr_en;
        logic [CH_W-1:0]  wr_lane;
        logic [BIT_W-1:0] bit_sel;
        logic [CH_W-1:0]  lane_count;
    } lane_ctl_t;

endpackage

>>> rtl/multichannel_bit_serial_driver.sv
// ----------------------------------------------------------------------------
// multichannel_bit_serial_driver
// Stores a channel-major sample payload behind an 8-byte header and shifts
// all channels out in parallel, one pin word per tick.
//
//   port group   dir  words
//   start/busy   in   req_type, rx_byte
//   done         out  result_kind, pin_word, last_word
//
// Other bytes do not raise busy; the last header byte holds it during checks.
// A tick within a loaded byte plane is emitted from the cached plane; the first
// tick of each sample byte first loads the plane, one channel byte per cycle
// through the single RAM read port, then passes S_WAIT and S_EMIT under busy.
// Results appear for one cycle on done; the receiver cannot stall.
// Reset clears control state only; the sample RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module multichannel_bit_serial_driver #(
    parameter int MAX_PAYLOAD_BYTES = 8192,
    parameter int MAX_CHANNELS      = 30
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic [msd_pkg::BYTE_W-1:0]  rx_byte,
    output logic                        done,
    output logic                        result_kind,
    output logic [msd_pkg::PIN_W-1:0]   pin_word,
    output logic                        last_word
);

    import msd_pkg::*;

    localparam int AW = $clog2(MAX_PAYLOAD_BYTES);

    typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_OUTPUT} phase_t;
    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_WAIT, S_EMIT} state_t;

    phase_t              phase_reg, phase_next;
    state_t              state_reg, state_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [SAMPLE_W-1:0] sm_reg, sm_next;
    logic [AW-1:0]       total_reg, total_next;
    logic [AW-1:0]       stride_reg, stride_next;
    logic [AW-1:0]       recv_reg, recv_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                bs_reg, bs_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                half_reg, half_next;
    logic                loaded_reg, loaded_next;
    logic [AW-1:0]       base_reg, base_next;
    logic [AW-1:0]       rd_addr_reg, rd_addr_next;
    logic [CH_W-1:0]     issue_reg, issue_next;
    logic                cap_valid_reg, cap_valid_next;
    logic [CH_W-1:0]     cap_lane_reg, cap_lane_next;
    logic                done_reg, done_next;
    logic                kind_reg, kind_next;
    logic [PIN_W-1:0]    pin_reg, pin_next;
    logic                last_reg, last_next;

    logic                  accept;
    logic                  emit;
    logic                  start_out;
    logic                  ram_we;
    logic                  ram_re;
    logic [BYTE_W-1:0]     ram_rdata;
    logic                  hdr_busy;
    logic                  hdr_byte_en;
    logic [AW-1:0]         hdr_total;
    hdr_res_t              hdr_res;
    lane_ctl_t             lane_ctl;
    logic [MAX_CHANNELS-1:0] lane_bits;

    assign busy        = (state_reg != S_IDLE) || hdr_busy;
    assign accept      = start && !busy;
    assign hdr_byte_en = accept && (req_type == REQ_BYTE) && (phase_reg == PH_HEADER);

    msd_hdr #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
        .MAX_CHANNELS      (MAX_CHANNELS)
    ) u_hdr (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (hdr_byte_en),
        .rx_byte (rx_byte),
        .res     (hdr_res),
        .busy    (hdr_busy),
        .total   (hdr_total)
    );

    msd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (recv_reg),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    assign lane_ctl.wr_en      = cap_valid_reg;
    assign lane_ctl.wr_lane    = cap_lane_reg;
    assign lane_ctl.bit_sel    = bit_reg;
    assign lane_ctl.lane_count = ch_reg;

    msd_lanes #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_lanes (
        .clk       (clk),
        .ctl       (lane_ctl),
        .wr_byte   (ram_rdata),
        .lane_bits (lane_bits)
    );

    always_comb
    begin
        phase_next     = phase_reg;
        state_next     = state_reg;
        ch_next        = ch_reg;
        sm_next        = sm_reg;
        total_next     = total_reg;
        stride_next    = stride_reg;
        recv_next      = recv_reg;
        sample_next    = sample_reg;
        bs_next        = bs_reg;
        bit_next       = bit_reg;
        half_next      = half_reg;
        loaded_next    = loaded_reg;
        base_next      = base_reg;
        rd_addr_next   = rd_addr_reg;
        issue_next     = issue_reg;
        cap_valid_next = 1'b0;
        cap_lane_next  = cap_lane_reg;
        done_next      = 1'b0;
        kind_next      = kind_reg;
        pin_next       = pin_reg;
        last_next      = last_reg;
        emit           = 1'b0;
        start_out      = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (hdr_res.valid)
                begin
                    if (hdr_res.reject)
                    begin
                        done_next = 1'b1;
                        kind_next = KIND_ERROR;
                        pin_next  = '0;
                        last_next = 1'b0;
                    end
                    else
                    begin
                        ch_next     = hdr_res.channels;
                        sm_next     = hdr_res.samples;
                        total_next  = hdr_total;
                        stride_next = AW'({hdr_res.samples, 1'b0});
                        recv_next   = '0;
                        if (hdr_res.zero_samples)
                        begin
                            phase_next = PH_HEADER;
                        end
                        else if (hdr_res.no_payload)
                        begin
                            start_out = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                else if (accept)
                begin
                    if (req_type == REQ_BYTE)
                    begin
                        if (phase_reg == PH_PAYLOAD)
                        begin
                            ram_we    = 1'b1;
                            recv_next = recv_reg + AW'(1);
                            if (({1'b0, recv_reg} + (AW+1)'(1)) >= {1'b0, total_reg})
                            begin
                                start_out = 1'b1;
                            end
                        end
                    end
                    else if (phase_reg == PH_OUTPUT)
                    begin
                        if (loaded_reg || (ch_reg == '0))
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            state_next   = S_LOAD;
                            issue_next   = '0;
                            rd_addr_next = base_reg;
                        end
                    end
                end
            end
            S_LOAD:
            begin
                ram_re         = 1'b1;
                cap_valid_next = 1'b1;
                cap_lane_next  = issue_reg;
                issue_next     = issue_reg + CH_W'(1);
                rd_addr_next   = rd_addr_reg + stride_reg;
                if (issue_reg == (ch_reg - CH_W'(1)))
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                loaded_next = 1'b1;
                emit        = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            done_next = 1'b1;
            kind_next = KIND_PINS;
            last_next = 1'b0;
            pin_next  = '0;
            pin_next[LANE_LSB +: MAX_CHANNELS] = lane_bits;
            pin_next[CLK_BIT]   = half_reg;
            pin_next[LATCH_BIT] = half_reg && !bs_reg && (bit_reg == BIT_W'(7));
            if (!half_reg)
            begin
                half_next = 1'b1;
            end
            else
            begin
                half_next = 1'b0;
                if (bit_reg != BIT_W'(7))
                begin
                    bit_next = bit_reg + BIT_W'(1);
                end
                else
                begin
                    bit_next    = '0;
                    loaded_next = 1'b0;
                    if (bs_reg)
                    begin
                        bs_next   = 1'b0;
                        base_next = base_reg - AW'(1);
                    end
                    else
                    begin
                        bs_next     = 1'b1;
                        base_next   = base_reg + AW'(3);
                        sample_next = sample_reg + SAMPLE_W'(1);
                        if (({1'b0, sample_reg} + (SAMPLE_W+1)'(1)) >= {1'b0, sm_reg})
                        begin
                            last_next   = 1'b1;
                            phase_next  = PH_HEADER;
                            sample_next = '0;
                        end
                    end
                end
            end
        end

        if (start_out)
        begin
            phase_next  = PH_OUTPUT;
            sample_next = '0;
            bs_next     = 1'b1;
            bit_next    = '0;
            half_next   = 1'b0;
            loaded_next = 1'b0;
            base_next   = AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            sm_reg        <= '0;
            total_reg     <= '0;
            stride_reg    <= '0;
            recv_reg      <= '0;
            sample_reg    <= '0;
            bs_reg        <= 1'b1;
            bit_reg       <= '0;
            half_reg      <= 1'b0;
            loaded_reg    <= 1'b0;
            base_reg      <= AW'(1);
            rd_addr_reg   <= '0;
            issue_reg     <= '0;
            cap_valid_reg <= 1'b0;
            cap_lane_reg  <= '0;
            done_reg      <= 1'b0;
            kind_reg      <= KIND_PINS;
            pin_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            sm_reg        <= sm_next;
            total_reg     <= total_next;
            stride_reg    <= stride_next;
            recv_reg      <= recv_next;
            sample_reg    <= sample_next;
            bs_reg        <= bs_next;
            bit_reg       <= bit_next;
            half_reg      <= half_next;
            loaded_reg    <= loaded_next;
            base_reg      <= base_next;
            rd_addr_reg   <= rd_addr_next;
            issue_reg     <= issue_next;
            cap_valid_reg <= cap_valid_next;
            cap_lane_reg  <= cap_lane_next;
            done_reg      <= done_next;
            kind_reg      <= kind_next;
            pin_reg       <= pin_next;
            last_reg      <= last_next;
        end
    end

    assign done        = done_reg;
    assign result_kind = kind_reg;
    assign pin_word    = pin_reg;
    assign last_word   = last_reg;

    // pin words only come out of the output phase
    a_pins_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result_kind == KIND_PINS)) |-> ($past(phase_reg) == PH_OUTPUT))
        else $error("pin word outside output phase");

    a_load_needs_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> ((ch_reg != '0) && (phase_reg == PH_OUTPUT)))
        else $error("plane load with no channels");

    a_capture_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cap_valid_reg |-> (cap_lane_reg < ch_reg))
        else $error("plane capture beyond channel count");

    a_header_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_res.valid |-> ((phase_reg == PH_HEADER) && (state_reg == S_IDLE)))
        else $error("header result outside header phase");

endmodule

>>> rtl/msd_ram.sv
// ----------------------------------------------------------------------------
// msd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module msd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/msd_hdr.sv
// ----------------------------------------------------------------------------
// msd_hdr
// Header collector: shifts in the 8-byte header, then checks the channel
// count and the payload size in the pipelined s1 and s2 steps.
// ----------------------------------------------------------------------------
module msd_hdr #(
    parameter int MAX_PAYLOAD_BYTES = 8192,
    parameter int MAX_CHANNELS      = 30
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 byte_en,
    input  logic [msd_pkg::BYTE_W-1:0]           rx_byte,
    output msd_pkg::hdr_res_t                    res,
    output logic                                 busy,
    output logic [$clog2(MAX_PAYLOAD_BYTES)-1:0] total
);

    import msd_pkg::*;

    localparam int AW     = $clog2(MAX_PAYLOAD_BYTES);
    localparam int PROD_W = CH_W + SAMPLE_W;
    localparam int TOT_W  = PROD_W + 1;

    logic [HDR_W-1:0]  header_reg, header_next;
    logic [2:0]        count_reg, count_next;
    logic              s1_reg, s1_next;
    logic              s2_reg, s2_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              big_reg, big_next;
    logic [TOT_W-1:0]  total_full;

    always_comb
    begin
        header_next = header_reg;
        count_next  = count_reg;
        s1_next     = 1'b0;
        s2_next     = s1_reg;
        prod_next   = prod_reg;
        big_next    = big_reg;
        if (byte_en)
        begin
            header_next = {header_reg[HDR_W-BYTE_W-1:0], rx_byte};
            if (count_reg == 3'd7)
            begin
                count_next = '0;
                s1_next    = 1'b1;
            end
            else
            begin
                count_next = count_reg + 3'd1;
            end
        end
        if (s1_reg)
        begin
            prod_next = PROD_W'(header_reg[SAMPLE_W +: CH_W]) *
                        PROD_W'(header_reg[SAMPLE_W-1:0]);
            big_next  = header_reg[HDR_W-1:SAMPLE_W] > SAMPLE_W'(MAX_CHANNELS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= '0;
            count_reg  <= '0;
            s1_reg     <= 1'b0;
            s2_reg     <= 1'b0;
        end
        else
        begin
            header_reg <= header_next;
            count_reg  <= count_next;
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        big_reg  <= big_next;
    end

    assign total_full       = {prod_reg, 1'b0};
    assign total            = total_full[AW-1:0];
    assign busy             = s1_reg || s2_reg;
    assign res.valid        = s2_reg;
    assign res.reject       = big_reg || (total_full >= TOT_W'(MAX_PAYLOAD_BYTES));
    assign res.zero_samples = header_reg[SAMPLE_W-1:0] == '0;
    assign res.no_payload   = prod_reg == '0;
    assign res.channels     = header_reg[SAMPLE_W +: CH_W];
    assign res.samples      = header_reg[SAMPLE_W-1:0];

endmodule

>>> rtl/msd_lanes.sv
// ----------------------------------------------------------------------------
// msd_lanes
// Byte-plane cache: one byte per channel for the current sample byte, and
// the selected bit of every active channel.
// ----------------------------------------------------------------------------
module msd_lanes #(
    parameter int MAX_CHANNELS = 30
) (
    input  logic                       clk,
    input  msd_pkg::lane_ctl_t         ctl,
    input  logic [msd_pkg::BYTE_W-1:0] wr_byte,
    output logic [MAX_CHANNELS-1:0]    lane_bits
);

    import msd_pkg::*;

    logic [BYTE_W-1:0] plane_reg [MAX_CHANNELS];

    for (genvar c = 0; c < MAX_CHANNELS; c++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (ctl.wr_en && (ctl.wr_lane == CH_W'(c)))
            begin
                plane_reg[c] <= wr_byte;
            end
        end

        assign lane_bits[c] = plane_reg[c][ctl.bit_sel] && (CH_W'(c) < ctl.lane_count);
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the multichannel bit-serial driver against a cycle-free predictor.
// Headers, sample payloads and output ticks go in through start/busy in bursts
// with random gaps; every pin word or header error on done is compared in
// order with the predicted result, including rejected headers, zero-sample
// and zero-channel transfers, and stray requests outside their phase.
// ----------------------------------------------------------------------------
module tb;

    import msd_pkg::*;

    localparam int STORE_BYTES  = 8192;
    localparam int STORE_AW     = $clog2(STORE_BYTES);
    localparam int LANES_MAX    = 30;
    localparam int TARGET_WORDS = 2000;
    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE_TICKS = 64;

    typedef enum logic [1:0] {
        LOAD_HEADER,
        LOAD_PAYLOAD,
        SHIFT_OUT
    } load_phase_t;

    typedef struct packed {
        logic              kind;
        logic [PIN_W-1:0]  pins;
        logic              last;
    } pin_result_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              start       = 1'b0;
    logic              req_type    = REQ_BYTE;
    logic [BYTE_W-1:0] rx_byte     = '0;
    logic              busy;
    logic              done;
    logic              result_kind;
    logic [PIN_W-1:0]  pin_word;
    logic              last_word;

    // driver state as seen from the pins
    load_phase_t       phase_q     = LOAD_HEADER;
    logic [HDR_W-1:0]  hdr_shift   = '0;
    int unsigned       hdr_cnt     = 0;
    int unsigned       lanes       = 0;
    longint unsigned   depth       = 0;
    longint unsigned   plane_total = 0;
    longint unsigned   plane_got   = 0;
    int unsigned       wr_lane     = 0;
    longint unsigned   wr_off      = 0;
    longint unsigned   rd_sample   = 0;
    logic              rd_byte_sel = 1'b1;
    int unsigned       rd_bit      = 0;
    logic              rd_half     = 1'b0;
    logic [7:0]        sample_ram [STORE_BYTES];

    pin_result_t       pin_words_due[$];
    int                errors      = 0;
    int                words_sent  = 0;
    int                burst_left  = 0;
    int                stall_count = 0;

    multichannel_bit_serial_driver #(
        .MAX_PAYLOAD_BYTES (STORE_BYTES),
        .MAX_CHANNELS      (LANES_MAX)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .rx_byte     (rx_byte),
        .done        (done),
        .result_kind (result_kind),
        .pin_word    (pin_word),
        .last_word   (last_word)
    );

    always #6 clk = ~clk;

    function automatic void begin_shift();
        phase_q     = SHIFT_OUT;
        rd_sample   = 0;
        rd_byte_sel = 1'b1;
        rd_bit      = 0;
        rd_half     = 1'b0;
    endfunction

    function automatic void advance_driver(input logic rt, input logic [7:0] b);
        longint unsigned lanes_req;
        longint unsigned depth_req;
        longint unsigned bytes_req;
        longint unsigned addr;
        logic [PIN_W-1:0] word;
        logic [7:0]       v;
        logic             last;
        if (rt == REQ_BYTE)
        begin
            if (phase_q == LOAD_HEADER)
            begin
                hdr_shift = {hdr_shift[HDR_W-9:0], b};
                if (hdr_cnt < 7)
                begin
                    hdr_cnt++;
                end
                else
                begin
                    hdr_cnt   = 0;
                    lanes_req = 64'(hdr_shift[63:32]);
                    depth_req = 64'(hdr_shift[31:0]);
                    bytes_req = lanes_req * depth_req * 64'd2;
                    if (lanes_req > LANES_MAX || bytes_req >= STORE_BYTES)
                    begin
                        pin_words_due.push_back('{KIND_ERROR, '0, 1'b0});
                    end
                    else
                    begin
                        lanes       = 32'(lanes_req);
                        depth       = depth_req;
                        plane_total = bytes_req;
                        plane_got   = 0;
                        wr_lane     = 0;
                        wr_off      = 0;
                        if (depth_req == 0)
                            phase_q = LOAD_HEADER;
                        else if (bytes_req == 0)
                            begin_shift();
                        else
                            phase_q = LOAD_PAYLOAD;
                    end
                end
            end
            else if (phase_q == LOAD_PAYLOAD)
            begin
                addr = 64'(wr_lane) * depth * 64'd2 + wr_off;
                if (addr < STORE_BYTES)
                    sample_ram[addr[STORE_AW-1:0]] = b;
                wr_off++;
                if (wr_off >= depth * 64'd2)
                begin
                    wr_off = 0;
                    wr_lane++;
                end
                plane_got++;
                if (plane_got >= plane_total)
                    begin_shift();
            end
        end
        else if (phase_q == SHIFT_OUT)
        begin
            word = '0;
            last = 1'b0;
            for (int unsigned c = 0; c < lanes && c < LANES_MAX; c++)
            begin
                addr = 64'(c) * depth * 64'd2 + rd_sample * 64'd2 + 64'(rd_byte_sel);
                v = (addr < STORE_BYTES) ? sample_ram[addr[STORE_AW-1:0]] : 8'd0;
                word[c + LANE_LSB] = v[rd_bit];
            end
            if (rd_half)
            begin
                word[CLK_BIT] = 1'b1;
                if (!rd_byte_sel && rd_bit == 7)
                    word[LATCH_BIT] = 1'b1;
                rd_half = 1'b0;
                if (rd_bit < 7)
                begin
                    rd_bit++;
                end
                else
                begin
                    rd_bit = 0;
                    if (rd_byte_sel)
                    begin
                        rd_byte_sel = 1'b0;
                    end
                    else
                    begin
                        rd_byte_sel = 1'b1;
                        rd_sample++;
                        if (rd_sample >= depth)
                        begin
                            last      = 1'b1;
                            phase_q   = LOAD_HEADER;
                            rd_sample = 0;
                        end
                    end
                end
            end
            else
            begin
                rd_half = 1'b1;
            end
            pin_words_due.push_back('{KIND_PINS, word, last});
        end
    endfunction

    task automatic send_word(input logic rt, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start    <= 1'b1;
        req_type <= rt;
        rx_byte  <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        advance_driver(rt, b);
        words_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pin_words_due.size() != 0);
    endtask

    task automatic send_header(input logic [31:0] ch, input logic [31:0] sm);
        logic [HDR_W-1:0] hdr;
        hdr = {ch, sm};
        for (int i = 7; i >= 0; i--)
            send_word(REQ_BYTE, hdr[i*8 +: 8]);
    endtask

    task automatic run_transfer(input logic [31:0] ch, input logic [31:0] sm,
                                input bit noisy, input bit all_ones);
        longint unsigned payload;
        longint unsigned ticks;
        payload = 64'(ch);
        send_header(ch, sm);
        if (ch > LANES_MAX)
            return;
        payload = payload * 64'(sm) * 64'd2;
        if (payload >= STORE_BYTES || sm == 0)
            return;
        for (longint unsigned i = 0; i < payload; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_word(REQ_TICK, 8'($urandom_range(0, 255)));
            send_word(REQ_BYTE, all_ones ? 8'hFF : 8'($urandom_range(0, 255)));
        end
        ticks = 64'(sm) * 64'd32;
        for (longint unsigned i = 0; i < ticks; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_word(REQ_BYTE, 8'($urandom_range(0, 255)));
            send_word(REQ_TICK, 8'($urandom_range(0, 255)));
        end
        if (noisy && $urandom_range(0, 1) == 0)
            send_word(REQ_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_requests_out_of_phase();
        send_word(REQ_TICK, 8'h00);
        send_word(REQ_TICK, 8'hFF);
    endtask

    task automatic test_rejected_headers();
        run_transfer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
        run_transfer(32'd31, 32'd1, 1'b0, 1'b0);
        run_transfer(32'd1, 32'd4096, 1'b0, 1'b0);
    endtask

    task automatic test_zero_samples();
        run_transfer(32'd30, 32'd0, 1'b0, 1'b0);
    endtask

    task automatic test_zero_channels();
        send_header(32'd0, 32'd1);
        send_word(REQ_BYTE, 8'hA5);
        for (int i = 0; i < 32; i++)
            send_word(REQ_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_all_lanes_high();
        run_transfer(32'd30, 32'd1, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_long_transfer();
        run_transfer(32'd30, 32'd8, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned     pick;
        logic [31:0]     ch;
        logic [31:0]     sm;
        while (words_sent < TARGET_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                ch = $urandom();
                if (ch <= LANES_MAX)
                    ch = ch + 32'd31;
                run_transfer(ch, $urandom(), 1'b0, 1'b0);
            end
            else if (pick < 13)
            begin
                ch = 32'($urandom_range(1, LANES_MAX));
                sm = 32'((STORE_BYTES + 2 * ch - 1) / (2 * ch));
                if ($urandom_range(0, 3) == 0)
                    sm = $urandom() | 32'h8000_0000;
                else if ($urandom_range(0, 1) == 0)
                    sm = sm + 32'($urandom_range(0, 1000));
                run_transfer(ch, sm, 1'b0, 1'b0);
            end
            else if (pick < 17)
            begin
                run_transfer(32'($urandom_range(0, LANES_MAX)), 32'd0, 1'b0, 1'b0);
            end
            else if (pick < 21)
            begin
                run_transfer(32'd0, 32'($urandom_range(1, 3)),
                             $urandom_range(0, 2) == 0, 1'b0);
            end
            else
            begin
                ch = 32'($urandom_range(1, LANES_MAX));
                sm = 32'($urandom_range(1, (ch <= 4) ? 6 : 2));
                run_transfer(ch, sm, $urandom_range(0, 2) == 0, 1'b0);
            end
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
    endtask

    always @(posedge clk)
    begin
        pin_result_t got;
        pin_result_t want;
        if (rst_n && done)
        begin
            got = '{result_kind, pin_word, last_word};
            if (pin_words_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got kind %0d pins %h last %0d",
                         $time, got.kind, got.pins, got.last);
                errors++;
            end
            else
            begin
                want = pin_words_due.pop_front();
                if (got !== want)
                begin
                    $display("%0t: result mismatch, expected kind %0d pins %h last %0d,",
                             $time, want.kind, want.pins, want.last);
                    $display("%0t:   got kind %0d pins %h last %0d",
                             $time, got.kind, got.pins, got.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_requests_out_of_phase();
        test_rejected_headers();
        test_zero_samples();
        test_zero_channels();
        test_all_lanes_high();
        test_long_transfer();
        test_random_traffic();
        wait_drained();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (errors == 0 && pin_words_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
